// ----- design/assert_macros.svh -----
// Assertion macros for the design files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication or sequence property on every rising clock edge outside reset.
`define MDSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define MDSC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- design/mdsc_pkg.sv -----
// Package with the widths, register codes, types and slope limiter of the sharpening core.
`timescale 1ns / 1ps

package mdsc_pkg;

   // Field widths.
   localparam int PIX_W  = 8;
   localparam int FRAC_W = 8;
   localparam int GAIN_W = 11;
   localparam int BASE_W = 11;
   localparam int ROW_W  = 4 * PIX_W;
   localparam int PAIR_W = 2 * PIX_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_SHARPEN_GAIN = 1'b0;
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

   // The gain is stored premultiplied by 29, the numerator of 29/64.
   localparam int SCALE_NUM = 29;
   localparam int GM_W      = GAIN_W + 5;
   localparam logic [GM_W-1:0] GAIN_M_RESET = GM_W'(256 * SCALE_NUM);

   // Datapath widths.
   localparam int PF_W   = 2 * FRAC_W - 1;           // x(1-x), at most 2^(2F-2)
   localparam int WT_W   = 3 * FRAC_W - 1;           // x(1-x)(1-y), at most 2^(3F-2)
   localparam int DIF_W  = PIX_W + 2;                // difference of two slopes
   localparam int TRM_W  = WT_W + 1 + DIF_W;         // signed weight times difference
   localparam int SUM_W  = TRM_W + 2;
   localparam int MAG_W  = 3 * FRAC_W + PIX_W;       // weights sum to at most 2^(3F-1)
   localparam int PROD_W = MAG_W + GM_W;
   localparam int TOTAL_SHIFT = 3 * FRAC_W + 8 + 6;
   localparam int Q_W    = PROD_W - TOTAL_SHIFT;
   localparam int RES_W  = BASE_W + 2;

   localparam int NSTAGE = 6;

   typedef logic signed [PIX_W:0]    slope_type;
   typedef logic signed [DIF_W-1:0]  diff_type;
   typedef logic [PF_W-1:0]          pf_type;
   typedef logic [WT_W-1:0]          weight_type;
   typedef logic signed [TRM_W-1:0]  term_type;
   typedef logic signed [BASE_W-1:0] base_type;

   // Zero when the two differences point opposite ways, else the one of
   // smaller magnitude, the second one on a tie.
   function automatic slope_type minmod(input slope_type a, input slope_type b);
      logic [PIX_W:0] ma;
      logic [PIX_W:0] mb;
      ma = a[PIX_W] ? $unsigned(-a) : $unsigned(a);
      mb = b[PIX_W] ? $unsigned(-b) : $unsigned(b);
      if ((a < 0 && b > 0) || (a > 0 && b < 0)) begin
         minmod = '0;
      end else begin
         minmod = (ma < mb) ? a : b;
      end
   endfunction

endpackage

// ----- design/mdsc_if.sv -----
// Valid/ready channel interfaces for the request and response words of the sharpening core.
`timescale 1ns / 1ps

interface mdsc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [mdsc_pkg::ROW_W-1:0]            upper_row;
   logic [mdsc_pkg::ROW_W-1:0]            lower_row;
   logic [mdsc_pkg::PAIR_W-1:0]           top_pair;
   logic [mdsc_pkg::PAIR_W-1:0]           bottom_pair;
   logic [mdsc_pkg::FRAC_W-1:0]           frac_x;
   logic [mdsc_pkg::FRAC_W-1:0]           frac_y;
   logic signed [mdsc_pkg::BASE_W-1:0]    base_value;

   modport source (
      output valid, upper_row, lower_row, top_pair, bottom_pair, frac_x, frac_y, base_value,
      input  ready
   );
   modport sink (
      input  valid, upper_row, lower_row, top_pair, bottom_pair, frac_x, frac_y, base_value,
      output ready
   );
endinterface

interface mdsc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mdsc_pkg::PIX_W-1:0] corrected_pixel;

   modport source (output valid, corrected_pixel, input ready);
   modport sink   (input valid, corrected_pixel, output ready);
endinterface

// ----- design/minmod_diagonal_sharpen_correction_core.sv -----
// Top level of the minmod slope-limited diagonal sharpening correction core.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake           Word
// req       in         valid/ready         four window rows, fractions, base value
// rsp       out        valid/ready         corrected 8-bit pixel
// csr       in/out     APB-style, pready=1 sharpen_gain at byte address 0
//
// The core is a six-stage pipeline and takes one word per clock while
// req.ready is high. A taken word moves through stages 0 to 5 in order, and
// rsp is driven from the stage 5 register.
// Reset clears the valid bits of all stages and sets the gain to 1.0.
// Each stage holds its word while the stage after it is full and stalled, so
// bubbles are squeezed out and req.ready drops only when every stage is full.

module minmod_diagonal_sharpen_correction_core (
   input  logic                                clock,
   input  logic                                reset,
   mdsc_req_if.sink                            req,
   mdsc_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mdsc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mdsc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mdsc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   // ---------------------------------------------------------------------
   // Configuration register. The gain is also kept multiplied by 29 so that
   // the final scaling stage needs only one multiplier.
   // ---------------------------------------------------------------------
   logic [mdsc_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [mdsc_pkg::GM_W-1:0]   gain_m_ff, gain_m_in;
   logic                        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == mdsc_pkg::REG_SHARPEN_GAIN);
   assign gain_in   = pwdata[mdsc_pkg::GAIN_W-1:0];
   assign gain_m_in = mdsc_pkg::GM_W'({5'b0, gain_in} * mdsc_pkg::GM_W'(mdsc_pkg::SCALE_NUM));

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= mdsc_pkg::GAIN_RESET;
         gain_m_ff <= mdsc_pkg::GAIN_M_RESET;
      end else if (csr_write) begin
         gain_ff   <= gain_in;
         gain_m_ff <= gain_m_in;
      end
   end

   always_comb begin
      if (paddr[2] == mdsc_pkg::REG_SHARPEN_GAIN) begin
         prdata = {{(mdsc_pkg::CSR_DATA_W - mdsc_pkg::GAIN_W){1'b0}}, gain_ff};
      end else begin
         prdata = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control. A stage loads when it is empty or when its word moves
   // on; the last stage is the output register. The advance chain is built
   // from the output side back toward the input.
   // ---------------------------------------------------------------------
   logic [mdsc_pkg::NSTAGE-1:0] v_ff, v_in, adv;

   always_comb begin
      for (int k = mdsc_pkg::NSTAGE - 1; k >= 0; k--) begin
         if (k == mdsc_pkg::NSTAGE - 1) begin
            adv[k] = !v_ff[k] || rsp.ready;
         end else begin
            adv[k] = !v_ff[k] || adv[k+1];
         end
         if (k == 0) begin
            v_in[k] = req.valid;
         end else begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < mdsc_pkg::NSTAGE; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   assign req.ready = adv[0];
   assign rsp.valid = v_ff[mdsc_pkg::NSTAGE-1];

   // ---------------------------------------------------------------------
   // Stage 0: unpack pixels, form the eight limited slopes and their four
   // differences, and the one-dimensional products x(1-x) and y(1-y).
   // ---------------------------------------------------------------------
   mdsc_pkg::slope_type d [4];
   mdsc_pkg::slope_type e [4];
   mdsc_pkg::slope_type u2, u3, q2, q3;
   mdsc_pkg::slope_type mxlu, mxru, mxld, mxrd, mylu, myld, myru, myrd;
   logic [mdsc_pkg::FRAC_W:0]       gx, gy;
   logic [2*mdsc_pkg::FRAC_W+1:0]   pfx_full, pfy_full;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         d[k] = $signed({1'b0, req.upper_row[k*mdsc_pkg::PIX_W +: mdsc_pkg::PIX_W]});
         e[k] = $signed({1'b0, req.lower_row[k*mdsc_pkg::PIX_W +: mdsc_pkg::PIX_W]});
      end
   end

   assign u2 = $signed({1'b0, req.top_pair[mdsc_pkg::PIX_W-1:0]});
   assign u3 = $signed({1'b0, req.top_pair[2*mdsc_pkg::PIX_W-1:mdsc_pkg::PIX_W]});
   assign q2 = $signed({1'b0, req.bottom_pair[mdsc_pkg::PIX_W-1:0]});
   assign q3 = $signed({1'b0, req.bottom_pair[2*mdsc_pkg::PIX_W-1:mdsc_pkg::PIX_W]});

   assign mxlu = mdsc_pkg::minmod(d[1] - d[0], d[2] - d[1]);
   assign mxru = mdsc_pkg::minmod(d[2] - d[1], d[3] - d[2]);
   assign mxld = mdsc_pkg::minmod(e[1] - e[0], e[2] - e[1]);
   assign mxrd = mdsc_pkg::minmod(e[2] - e[1], e[3] - e[2]);
   assign mylu = mdsc_pkg::minmod(d[1] - u2, e[1] - d[1]);
   assign myld = mdsc_pkg::minmod(e[1] - d[1], q2 - e[1]);
   assign myru = mdsc_pkg::minmod(d[2] - u3, e[2] - d[2]);
   assign myrd = mdsc_pkg::minmod(e[2] - d[2], q3 - e[2]);

   // One minus the fraction, in the same units; a zero fraction gives 2^F.
   assign gx = (mdsc_pkg::FRAC_W+1)'(1 << mdsc_pkg::FRAC_W) - {1'b0, req.frac_x};
   assign gy = (mdsc_pkg::FRAC_W+1)'(1 << mdsc_pkg::FRAC_W) - {1'b0, req.frac_y};
   assign pfx_full = gx * {1'b0, req.frac_x};
   assign pfy_full = gy * {1'b0, req.frac_y};

   mdsc_pkg::diff_type           s0_dx0_ff, s0_dx1_ff, s0_dy0_ff, s0_dy1_ff;
   mdsc_pkg::pf_type             s0_pfx_ff, s0_pfy_ff;
   logic [mdsc_pkg::FRAC_W-1:0]  s0_fx_ff, s0_fy_ff;
   logic [mdsc_pkg::FRAC_W:0]    s0_gx_ff, s0_gy_ff;
   mdsc_pkg::base_type           s0_base_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_dx0_ff  <= mdsc_pkg::diff_type'(mxlu) - mdsc_pkg::diff_type'(mxru);
         s0_dx1_ff  <= mdsc_pkg::diff_type'(mxld) - mdsc_pkg::diff_type'(mxrd);
         s0_dy0_ff  <= mdsc_pkg::diff_type'(mylu) - mdsc_pkg::diff_type'(myld);
         s0_dy1_ff  <= mdsc_pkg::diff_type'(myru) - mdsc_pkg::diff_type'(myrd);
         s0_pfx_ff  <= pfx_full[mdsc_pkg::PF_W-1:0];
         s0_pfy_ff  <= pfy_full[mdsc_pkg::PF_W-1:0];
         s0_fx_ff   <= req.frac_x;
         s0_fy_ff   <= req.frac_y;
         s0_gx_ff   <= gx;
         s0_gy_ff   <= gy;
         s0_base_ff <= req.base_value;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: the four position weights.
   // ---------------------------------------------------------------------
   logic [mdsc_pkg::WT_W:0] w0_full, w1_full, w2_full, w3_full;

   assign w0_full = s0_pfx_ff * s0_gy_ff;
   assign w1_full = s0_pfx_ff * {1'b0, s0_fy_ff};
   assign w2_full = s0_pfy_ff * s0_gx_ff;
   assign w3_full = s0_pfy_ff * {1'b0, s0_fx_ff};

   mdsc_pkg::weight_type s1_w0_ff, s1_w1_ff, s1_w2_ff, s1_w3_ff;
   mdsc_pkg::diff_type   s1_dx0_ff, s1_dx1_ff, s1_dy0_ff, s1_dy1_ff;
   mdsc_pkg::base_type   s1_base_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_w0_ff   <= w0_full[mdsc_pkg::WT_W-1:0];
         s1_w1_ff   <= w1_full[mdsc_pkg::WT_W-1:0];
         s1_w2_ff   <= w2_full[mdsc_pkg::WT_W-1:0];
         s1_w3_ff   <= w3_full[mdsc_pkg::WT_W-1:0];
         s1_dx0_ff  <= s0_dx0_ff;
         s1_dx1_ff  <= s0_dx1_ff;
         s1_dy0_ff  <= s0_dy0_ff;
         s1_dy1_ff  <= s0_dy1_ff;
         s1_base_ff <= s0_base_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: each weight times its slope difference.
   // ---------------------------------------------------------------------
   mdsc_pkg::term_type s2_t0_ff, s2_t1_ff, s2_t2_ff, s2_t3_ff;
   mdsc_pkg::base_type s2_base_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_t0_ff   <= $signed({1'b0, s1_w0_ff}) * s1_dx0_ff;
         s2_t1_ff   <= $signed({1'b0, s1_w1_ff}) * s1_dx1_ff;
         s2_t2_ff   <= $signed({1'b0, s1_w2_ff}) * s1_dy0_ff;
         s2_t3_ff   <= $signed({1'b0, s1_w3_ff}) * s1_dy1_ff;
         s2_base_ff <= s1_base_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: sum of the four terms, split into sign and magnitude. The
   // weights add up to at most half of 2^(3F), so the magnitude fits MAG_W.
   // ---------------------------------------------------------------------
   logic signed [mdsc_pkg::SUM_W-1:0] sum;
   logic [mdsc_pkg::SUM_W-1:0]        sum_abs;

   assign sum = mdsc_pkg::SUM_W'(s2_t0_ff) + mdsc_pkg::SUM_W'(s2_t1_ff)
              + mdsc_pkg::SUM_W'(s2_t2_ff) + mdsc_pkg::SUM_W'(s2_t3_ff);
   assign sum_abs = sum[mdsc_pkg::SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);

   logic [mdsc_pkg::MAG_W-1:0] s3_mag_ff;
   logic                       s3_neg_ff;
   mdsc_pkg::base_type         s3_base_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_mag_ff  <= sum_abs[mdsc_pkg::MAG_W-1:0];
         s3_neg_ff  <= sum[mdsc_pkg::SUM_W-1];
         s3_base_ff <= s2_base_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: magnitude times gain times 29.
   // ---------------------------------------------------------------------
   logic [mdsc_pkg::PROD_W-1:0] s4_prod_ff;
   logic                        s4_neg_ff;
   mdsc_pkg::base_type          s4_base_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_prod_ff <= s3_mag_ff * gain_m_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_base_ff <= s3_base_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: drop the fraction bits, add to the base with truncation toward
   // zero of the exact total, and clamp to the pixel range.
   // ---------------------------------------------------------------------
   logic [mdsc_pkg::Q_W-1:0]          q;
   logic                              frac;
   logic signed [mdsc_pkg::RES_W-1:0] base_ext, q_ext, r_sum, r_adj;
   logic [mdsc_pkg::PIX_W-1:0]        pixel;

   assign q        = s4_prod_ff[mdsc_pkg::PROD_W-1:mdsc_pkg::TOTAL_SHIFT];
   assign frac     = |s4_prod_ff[mdsc_pkg::TOTAL_SHIFT-1:0];
   assign base_ext = mdsc_pkg::RES_W'(s4_base_ff);
   assign q_ext    = $signed({{(mdsc_pkg::RES_W - mdsc_pkg::Q_W){1'b0}}, q});

   always_comb begin
      if (!s4_neg_ff) begin
         r_sum = base_ext + q_ext;
         r_adj = (frac && r_sum < 0) ? r_sum + mdsc_pkg::RES_W'(1) : r_sum;
      end else begin
         r_sum = base_ext - q_ext;
         r_adj = (frac && r_sum > 0) ? r_sum - mdsc_pkg::RES_W'(1) : r_sum;
      end
      if (r_adj < 0) begin
         pixel = '0;
      end else if (r_adj > $signed({{(mdsc_pkg::RES_W - mdsc_pkg::PIX_W){1'b0}},
                                    {mdsc_pkg::PIX_W{1'b1}}})) begin
         pixel = '1;
      end else begin
         pixel = r_adj[mdsc_pkg::PIX_W-1:0];
      end
   end

   logic [mdsc_pkg::PIX_W-1:0] s5_pixel_ff;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_pixel_ff <= pixel;
      end
   end

   assign rsp.corrected_pixel = s5_pixel_ff;

   // ---------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------
   `MDSC_ASSERT(a_accept_fills_first, clock, reset,
                req.valid && req.ready |=> v_ff[0],
                "accepted word did not enter the first stage")
   `MDSC_ASSERT(a_held_stage_keeps, clock, reset,
                v_ff[3] && !adv[3] |=> v_ff[3],
                "a stalled stage dropped its word")
   `MDSC_ASSERT_NEVER(a_no_bubble_stall, clock, reset,
                      !req.ready && !(&v_ff),
                      "input stalled while a stage was empty")

endmodule
